// ===== src/frta_pkg.sv =====
// shared constants and types of the frame ring temporal averaging core
package frta_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned DATA_W     = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned MODE_W     = 2;

  // frame count and slot arithmetic cover up to sixteen frames
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SLOT_W = 4;

  // equal-weight division by reciprocal
  localparam int unsigned EQ_W      = SAMPLE_W + CNT_W;
  localparam int unsigned RCP_SHIFT = EQ_W + CNT_W;
  localparam int unsigned RCP_W     = RCP_SHIFT + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;

  // averaging modes
  localparam logic [MODE_W-1:0] MODE_EQUAL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEWEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECR   = 2'd2;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] FRAMES_RST = 4'd8;

  // controls for the weighting stage
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  frames;
    logic [SLOT_W-1:0] slot;
    logic              pix_ok;
  } wt_ctrl_t;

  // controls for the divide and round stages
  typedef struct packed {
    logic             eq;
    logic [CNT_W-1:0] dsh;
    logic [CNT_W-1:0] frames;
  } dv_ctrl_t;

endpackage

// ===== src/frta_store.sv =====
// frame store: one row per pixel holding all frame samples, with clearing sweep
module frta_store #(
  parameter int unsigned PIXEL_COUNT = 4096,
  parameter int unsigned ROW_W       = 64,
  parameter int unsigned AW          = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_start_i,
  output logic             clr_busy_o,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i
);

  logic [ROW_W-1:0] mem [PIXEL_COUNT];
  logic [ROW_W-1:0] rd_data_q;
  logic             busy_q, busy_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic             cnt_last;

  assign cnt_last = (32'(cnt_q) == 32'(PIXEL_COUNT - 1));

  // clearing sweep control, restarted by a frame count write
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (clr_start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_last) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // memory port: sweep writes win over item writes
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = busy_q;

endmodule

// ===== src/frta_weight.sv =====
// per-frame weighting of one pixel row and the weighted sum
module frta_weight #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 mrg_en_i,
  input  logic                                 sum_en_i,
  input  logic [MAX_FRAMES*frta_pkg::SAMPLE_W-1:0] row_i,
  input  frta_pkg::wt_ctrl_t                   ctrl_i,
  output logic [frta_pkg::SAMPLE_W+MAX_FRAMES+frta_pkg::SLOT_W-1:0] num_o,
  output frta_pkg::dv_ctrl_t                   dv_o
);
  import frta_pkg::*;

  localparam int unsigned TW   = SAMPLE_W + MAX_FRAMES - 1;
  localparam int unsigned NUMW = SAMPLE_W + MAX_FRAMES + SLOT_W;
  localparam int unsigned KW   = CNT_W + 1;

  logic [TW-1:0]   terms_q [MAX_FRAMES];
  logic [TW-1:0]   terms_d [MAX_FRAMES];
  wt_ctrl_t        ctrl_q;
  logic [NUMW-1:0] num_q, num_d;
  dv_ctrl_t        dv_q, dv_d;

  // shift of each frame sample by its age
  always_comb begin
    logic [SAMPLE_W-1:0] x;
    logic [KW-1:0]       k1;
    logic [KW-1:0]       k2;
    logic [SLOT_W-1:0]   sh;
    logic                in_use;
    x      = '0;
    k1     = '0;
    k2     = '0;
    sh     = '0;
    in_use = 1'b0;
    for (int s = 0; s < MAX_FRAMES; s++) begin
      x      = row_i[SAMPLE_W*s +: SAMPLE_W];
      in_use = ctrl_i.pix_ok && (KW'(s) < KW'(ctrl_i.frames));
      // age counted from the oldest frame
      k1 = KW'(s) + KW'(ctrl_i.frames) - KW'(ctrl_i.slot) - KW'(1);
      if (k1 >= KW'(ctrl_i.frames)) begin
        k1 = k1 - KW'(ctrl_i.frames);
      end
      // age counted from the newest frame
      k2 = KW'(ctrl_i.slot) + KW'(ctrl_i.frames) - KW'(s);
      if (k2 >= KW'(ctrl_i.frames)) begin
        k2 = k2 - KW'(ctrl_i.frames);
      end
      case (ctrl_i.mode)
        MODE_NEWEST: sh = (k1 == '0) ? '0 : SLOT_W'(k1 - KW'(1));
        MODE_DECR:   sh = SLOT_W'(KW'(ctrl_i.frames) - KW'(1) - k2);
        default:     sh = '0;
      endcase
      terms_d[s] = in_use ? (TW'(x) << sh) : '0;
    end
  end

  // sum of the weighted terms and the divisor for the next stages
  always_comb begin
    num_d = '0;
    for (int s = 0; s < MAX_FRAMES; s++) begin
      num_d = num_d + NUMW'(terms_q[s]);
    end
    dv_d.frames = ctrl_q.frames;
    case (ctrl_q.mode)
      MODE_NEWEST: begin
        dv_d.eq  = 1'b0;
        dv_d.dsh = ctrl_q.frames - CNT_W'(1);
      end
      MODE_DECR: begin
        dv_d.eq  = 1'b0;
        dv_d.dsh = ctrl_q.frames;
      end
      default: begin
        dv_d.eq  = 1'b1;
        dv_d.dsh = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (mrg_en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mrg_en_i) begin
      terms_q <= terms_d;
    end
    if (sum_en_i) begin
      num_q <= num_d;
      dv_q  <= dv_d;
    end
  end

  assign num_o = num_q;
  assign dv_o  = dv_q;

endmodule

// ===== src/frta_div.sv =====
// divide by frame count or power of two, round half to even, saturate
module frta_div #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                               clk_i,
  input  logic                               div_en_i,
  input  logic [frta_pkg::SAMPLE_W+MAX_FRAMES+frta_pkg::SLOT_W-1:0] num_i,
  input  frta_pkg::dv_ctrl_t                 dv_i,
  output logic [frta_pkg::SAMPLE_W-1:0]      result_o
);
  import frta_pkg::*;

  localparam int unsigned NUMW = SAMPLE_W + MAX_FRAMES + SLOT_W;
  localparam int unsigned DENW = MAX_FRAMES + 1;
  localparam int unsigned TABN = 2 ** CNT_W;

  logic [RCP_W-1:0]        recip [TABN];
  logic [EQ_W+RCP_W-1:0]   prod_eq;
  logic [NUMW-1:0]         q_d, q_q;
  logic [NUMW-1:0]         num_q;
  logic [DENW-1:0]         den_d, den_q;
  logic                    eq_q;
  logic [CNT_W-1:0]        frames_q;
  logic [EQ_W-1:0]         back_eq;
  logic [NUMW-1:0]         rem_wide;
  logic [DENW-1:0]         rem;
  logic                    round_up;
  logic [NUMW:0]           q_rnd;

  // reciprocal table, ceil(2^shift / n)
  assign recip[0] = '0;
  for (genvar g = 1; g < TABN; g++) begin : g_rcp
    localparam longint unsigned RV = ((64'd1 << RCP_SHIFT) + g - 1) / g;
    assign recip[g] = RCP_W'(RV);
  end

  // quotient: reciprocal multiply for equal weights, shift otherwise
  assign prod_eq = (EQ_W+RCP_W)'(num_i[EQ_W-1:0]) * (EQ_W+RCP_W)'(recip[dv_i.frames]);

  always_comb begin
    if (dv_i.eq) begin
      q_d   = NUMW'(prod_eq >> RCP_SHIFT);
      den_d = DENW'(dv_i.frames);
    end else begin
      q_d   = num_i >> dv_i.dsh;
      den_d = DENW'(1) << dv_i.dsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_en_i) begin
      q_q      <= q_d;
      num_q    <= num_i;
      den_q    <= den_d;
      eq_q     <= dv_i.eq;
      frames_q <= dv_i.frames;
    end
  end

  // remainder, then round half to even and saturate
  assign back_eq = EQ_W'(q_q[SAMPLE_W-1:0]) * EQ_W'(frames_q);

  always_comb begin
    if (eq_q) begin
      rem_wide = NUMW'(num_q[EQ_W-1:0] - back_eq);
    end else begin
      rem_wide = num_q & NUMW'(den_q - DENW'(1));
    end
    rem      = rem_wide[DENW-1:0];
    round_up = ({rem, 1'b0} > {1'b0, den_q}) ||
               (({rem, 1'b0} == {1'b0, den_q}) && q_q[0]);
    q_rnd    = {1'b0, q_q} + (NUMW+1)'(round_up);
    if (q_rnd > (NUMW+1)'(255)) begin
      result_o = '1;
    end else begin
      result_o = q_rnd[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== src/frame_ring_temporal_average_core.sv =====
// Temporal averaging over a ring of up to MAX_FRAMES frames kept in one wide
// memory row per pixel. Each accepted sample is merged into the current frame
// slot of its pixel's row and one filtered sample comes back per transfer.
// An item passes from acceptance to a registered result through memory
// read, merge and write back, weighted sum, and divide and round; the next
// item is accepted in the cycle its predecessor's result is registered, and
// not before, since the sequencer carries a single item at a time through all
// four steps. After reset and after every write of frames_in_use the store
// is swept to zero over all PIXEL_COUNT rows, during which no input transfer
// is accepted.
module frame_ring_temporal_average_core #(
  parameter int unsigned PIXEL_COUNT = 4096,
  parameter int unsigned MAX_FRAMES  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [frta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [frta_pkg::DATA_W-1:0]    s_axis_tdata,  // pixel_index[11:0], sample[19:12]
  input  logic                           s_axis_tlast,  // frame_end
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [frta_pkg::DATA_W-1:0]    m_axis_tdata   // out_index[11:0], filtered_sample[19:12]
);
  import frta_pkg::*;

  localparam int unsigned AW    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned SLW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned ROW_W = MAX_FRAMES * SAMPLE_W;
  localparam int unsigned NUMW  = SAMPLE_W + MAX_FRAMES + SLOT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRG  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] frames_q;
  logic [MODE_W-1:0]     mode_q;
  logic [SLW-1:0]        slot_q, slot_d;
  logic [CNT_W-1:0]      n_eff;
  logic [INDEX_W-1:0]    pix_q;
  logic [SAMPLE_W-1:0]   smp_q;
  logic                  last_q;
  logic                  pix_ok;
  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  clr_start;
  logic                  clr_busy;
  logic                  out_load;
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      row_mrg;
  wt_ctrl_t              wt_ctrl;
  logic [NUMW-1:0]       num;
  dv_ctrl_t              dv_ctrl;
  logic [SAMPLE_W-1:0]   result;
  logic                  out_valid_q;
  logic [INDEX_W-1:0]    out_idx_q;
  logic [SAMPLE_W-1:0]   out_smp_q;

  // configuration port
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign clr_start   = cfg_xfer && (cfg_index_i == REG_FRAMES);

  // effective frame count: zero acts as one, above the ring size saturates
  always_comb begin
    if (frames_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(frames_q) > CNT_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(frames_q);
    end
  end

  // handshakes
  assign out_load      = (state_q == S_RND) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy && ((state_q == S_IDLE) || out_load);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign pix_ok        = (32'(pix_q) < 32'(PIXEL_COUNT));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_MRG;
      S_MRG:  state_d = S_SUM;
      S_SUM:  state_d = S_DIV;
      S_DIV:  state_d = S_RND;
      S_RND: begin
        if (in_xfer) begin
          state_d = S_MRG;
        end else if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // merge the new sample into its frame slot
  always_comb begin
    row_mrg = rd_row;
    row_mrg[SAMPLE_W*slot_q +: SAMPLE_W] = smp_q;
  end

  // slot advance after the last sample of a frame
  always_comb begin
    slot_d = slot_q;
    if (clr_start) begin
      slot_d = '0;
    end else if ((state_q == S_MRG) && last_q) begin
      if (CNT_W'(slot_q) + CNT_W'(1) >= n_eff) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + SLW'(1);
      end
    end
  end

  assign wt_ctrl.mode   = mode_q;
  assign wt_ctrl.frames = n_eff;
  assign wt_ctrl.slot   = SLOT_W'(slot_q);
  assign wt_ctrl.pix_ok = pix_ok;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frames_q    <= FRAMES_RST;
      mode_q      <= MODE_EQUAL;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (clr_start) begin
        frames_q <= cfg_data_i;
      end
      if (cfg_xfer && (cfg_index_i == REG_MODE)) begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q  <= s_axis_tdata[INDEX_W-1:0];
      smp_q  <= s_axis_tdata[INDEX_W +: SAMPLE_W];
      last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_idx_q <= pix_q;
      out_smp_q <= result;
    end
  end

  frta_store #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .ROW_W       (ROW_W),
    .AW          (AW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_start_i (clr_start),
    .clr_busy_o  (clr_busy),
    .rd_en_i     (in_xfer),
    .rd_addr_i   (AW'(s_axis_tdata[INDEX_W-1:0])),
    .rd_data_o   (rd_row),
    .wr_en_i     ((state_q == S_MRG) && pix_ok),
    .wr_addr_i   (AW'(pix_q)),
    .wr_data_i   (row_mrg)
  );

  frta_weight #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mrg_en_i (state_q == S_MRG),
    .sum_en_i (state_q == S_SUM),
    .row_i    (row_mrg),
    .ctrl_i   (wt_ctrl),
    .num_o    (num),
    .dv_o     (dv_ctrl)
  );

  frta_div #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_div (
    .clk_i    (clk_i),
    .div_en_i (state_q == S_DIV),
    .num_i    (num),
    .dv_i     (dv_ctrl),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'({out_smp_q, out_idx_q});

  // no item enters while the store is being swept
  a_no_xfer_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !clr_busy)
    else $error("input transfer during clearing sweep");

  // an accepted item always goes to the merge step next
  a_xfer_to_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_MRG))
    else $error("accepted item did not reach merge");

  // the write slot stays inside the ring in use
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(slot_q) < n_eff)
    else $error("write slot beyond frame count");

  // a frame count write starts the clearing sweep
  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_start |=> clr_busy)
    else $error("frame count write did not start clearing");

endmodule

// ===== sim/frame_ring_temporal_average_core_test.sv =====
// self-checking stream testbench for the frame ring temporal averaging core
`timescale 1ns / 100ps

module frame_ring_temporal_average_core_test;
  import frta_pkg::*;

  localparam int unsigned PIXELS      = 4096;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned PHASES      = 13;
  localparam int unsigned RAND_ITEMS  = 48;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int          KEEP        = -1;

  typedef struct packed {
    logic [INDEX_W-1:0]  pix;
    logic [SAMPLE_W-1:0] smp;
    logic                last;
  } pixel_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [SAMPLE_W-1:0] val;
  } filtered_pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_FRAMES;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;

  frame_ring_temporal_average_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // pixel_index[11:0], sample[19:12]
    .s_axis_tlast  (s_axis_tlast),   // frame_end
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // out_index[11:0], filtered_sample[19:12]
  );

  // mirror of the frame ring and its settings
  logic [SAMPLE_W-1:0]   ring_store [PIXELS][SLOTS];
  int unsigned           newest_slot;
  logic [CFG_DATA_W-1:0] frame_count_reg;
  logic [MODE_W-1:0]     weighting_reg;

  pixel_item_t     sample_queue[$];
  filtered_pixel_t expected_pixels[$];
  pixel_item_t     next_item;

  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned setting_count = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  // phase settings, KEEP leaves a register untouched
  int phase_frames [PHASES] = '{KEEP, 1, 0, 15, KEEP, 8, 3, 5, KEEP, 2, 7, 9, 6};
  int phase_mode   [PHASES] = '{KEEP, 1, 2, 1, 3, 2, 0, 1, 2, 3, 0, 2, 1};

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_frames();
    int unsigned n;
    n = frame_count_reg;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // exact weighted value of one pixel, rounded half to even, clipped to 255
  function automatic logic [SAMPLE_W-1:0] average_pixel(logic [INDEX_W-1:0] pix);
    int unsigned       n;
    int unsigned       k;
    int unsigned       s;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   q;
    longint unsigned   r;
    n   = active_frames();
    num = 0;
    case (weighting_reg)
      MODE_NEWEST: begin
        // oldest frame first, the two oldest weigh the same, each newer one twice the previous
        for (k = 0; k < n; k++) begin
          s = (newest_slot + 1 + k) % n;
          if (k == 0) num += ring_store[pix][s];
          else num += longint'(ring_store[pix][s]) << (k - 1);
        end
        den = 64'd1 << (n - 1);
      end
      MODE_DECR: begin
        // newest weighs 1/2, the next 1/4 and so on
        for (k = 0; k < n; k++) begin
          s = (newest_slot + n - k) % n;
          num += longint'(ring_store[pix][s]) << (n - 1 - k);
        end
        den = 64'd1 << n;
      end
      default: begin
        for (k = 0; k < n; k++) num += ring_store[pix][k];
        den = n;
      end
    endcase
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    if (q > 255) q = 255;
    return q[SAMPLE_W-1:0];
  endfunction

  // merge one accepted sample and queue the value it should produce
  task automatic store_and_predict(logic [INDEX_W-1:0] pix, logic [SAMPLE_W-1:0] smp,
                                   logic last);
    int unsigned     n;
    filtered_pixel_t exp_px;
    n = active_frames();
    if (newest_slot >= n) newest_slot = 0;
    ring_store[pix][newest_slot] = smp;
    exp_px.idx = pix;
    exp_px.val = average_pixel(pix);
    expected_pixels.push_back(exp_px);
    if (last) newest_slot = (newest_slot + 1 >= n) ? 0 : newest_slot + 1;
  endtask

  task automatic clear_ring();
    int unsigned p;
    int unsigned s;
    for (p = 0; p < PIXELS; p++)
      for (s = 0; s < SLOTS; s++) ring_store[p][s] = '0;
    newest_slot = 0;
  endtask

  task automatic queue_sample(logic [INDEX_W-1:0] pix, logic [SAMPLE_W-1:0] smp, logic last);
    pixel_item_t item;
    item.pix  = pix;
    item.smp  = smp;
    item.last = last;
    sample_queue.push_back(item);
  endtask

  // frames of a few samples over a small set of hot pixels, with some stray ones
  task automatic queue_random_frames(int unsigned count);
    logic [INDEX_W-1:0]  hot [6];
    logic [INDEX_W-1:0]  pix;
    logic [SAMPLE_W-1:0] smp;
    logic                last;
    int unsigned         made;
    int unsigned         len;
    int unsigned         k;
    for (k = 0; k < 6; k++) hot[k] = INDEX_W'($urandom_range(PIXELS - 1, 0));
    made = 0;
    while (made < count) begin
      len = $urandom_range(6, 1);
      for (k = 0; k < len && made < count; k++) begin
        if ($urandom_range(9, 0) < 8) pix = hot[$urandom_range(5, 0)];
        else pix = INDEX_W'($urandom);
        case ($urandom_range(5, 0))
          0: smp = '0;
          1: smp = '1;
          default: smp = SAMPLE_W'($urandom);
        endcase
        last = (k == len - 1);
        // occasionally broken framing
        if ($urandom_range(9, 0) == 0) last = ~last;
        queue_sample(pix, smp, last);
        made++;
      end
    end
  endtask

  // one configuration transfer, mirrored once it is taken
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_FRAMES) begin
      frame_count_reg = val;
      clear_ring();
    end else begin
      weighting_reg = val[MODE_W-1:0];
    end
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        store_and_predict(s_axis_tdata[INDEX_W-1:0], s_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W],
                          s_axis_tlast);
        sent_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(99, 0) < send_idle_pct) begin
          send_gap = $urandom_range(15, 0);
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          next_item = sample_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(DATA_W - INDEX_W - SAMPLE_W){1'b0}}, next_item.smp, next_item.pix};
          s_axis_tlast  <= next_item.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk_i) begin
    filtered_pixel_t exp_px;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result transfer: index %0d value %0d",
                     m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W]);
        end else begin
          exp_px = expected_pixels.pop_front();
          checked_count++;
          if (m_axis_tdata[INDEX_W-1:0] !== exp_px.idx ||
              m_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W] !== exp_px.val) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: expected index %0d value %0d, got index %0d value %0d",
                       exp_px.idx, exp_px.val, m_axis_tdata[INDEX_W-1:0],
                       m_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W]);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
        recv_gap = $urandom_range(15, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_ring_temporal_average_core_test: FAIL");
      $finish;
    end
  end

  // reset, then phases of register settings and samples
  initial begin
    int unsigned ph;
    int unsigned k;
    frame_count_reg = FRAMES_RST;
    weighting_reg   = MODE_EQUAL;
    clear_ring();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) wait_drained();
      if (phase_frames[ph] != KEEP) write_register(REG_FRAMES, CFG_DATA_W'(phase_frames[ph]));
      if (phase_mode[ph] != KEEP) write_register(REG_MODE, CFG_DATA_W'(phase_mode[ph]));
      setting_count++;
      // no idling in the closing phase
      if (ph == PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(2, 0))
          0: send_idle_pct = 0;
          1: send_idle_pct = 25;
          default: send_idle_pct = 60;
        endcase
        case ($urandom_range(2, 0))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 25;
          default: recv_idle_pct = 60;
        endcase
      end
      case (ph)
        0: begin
          // full-scale pixel over every slot, slot wrap, overwrite within a frame,
          // half-way ties on an eight-frame mean
          for (k = 0; k < SLOTS; k++) queue_sample('0, '1, 1'b1);
          queue_sample('1, '1, 1'b0);
          queue_sample('1, '0, 1'b0);
          queue_sample('1, 8'd1, 1'b1);
          queue_sample(12'd7, 8'd4, 1'b0);
          queue_sample(12'd8, 8'd12, 1'b0);
        end
        2: begin
          // frame count zero behaves as one, halving ties
          queue_sample('1, '1, 1'b1);
          queue_sample('1, 8'd1, 1'b1);
          queue_sample('1, 8'd3, 1'b0);
        end
        3: begin
          // oversized frame count behaves as eight, newest first at full scale
          for (k = 0; k < SLOTS; k++) queue_sample('0, '1, 1'b1);
        end
        default: ;
      endcase
      queue_random_frames(RAND_ITEMS);
    end
    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("%0d sample transfers over %0d register settings, %0d filtered results checked",
             sent_count, setting_count, checked_count);
    $display("%0d mismatches", error_count);
    if (error_count == 0) begin
      $display("frame_ring_temporal_average_core_test: PASS");
    end else begin
      $display("frame_ring_temporal_average_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/frta_pkg.sv
src/frta_store.sv
src/frta_weight.sv
src/frta_div.sv
src/frame_ring_temporal_average_core.sv
sim/frame_ring_temporal_average_core_test.sv
